@@ hdl/rtc_pkg.sv @@
package rtc_pkg;

    localparam int VALUE_BITS_DEF = 28;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;

    localparam logic [7:0] CHAR_ZERO      = 8'd48;
    localparam logic [7:0] CHAR_ONE       = 8'd49;
    localparam logic [7:0] CHAR_NINE      = 8'd57;
    localparam logic [7:0] CHAR_UPPER_A   = 8'd65;
    localparam logic [7:0] CHAR_UPPER_F   = 8'd70;
    localparam logic [7:0] CHAR_LOWER_A   = 8'd97;
    localparam logic [7:0] CHAR_LOWER_F   = 8'd102;
    localparam logic [7:0] HEX_UPPER_OFS  = 8'd55;
    localparam logic [7:0] HEX_LOWER_OFS  = 8'd87;

    typedef struct packed {
        logic step;
        logic scan;
        logic latch;
        logic emit_bin;
        logic emit_hex;
        logic emit_bad;
    } rtc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic step_bad;
        logic bit_hit;
        logic ptr_zero;
        logic nib_zero;
    } rtc_stat_t;

endpackage

@@ hdl/radix_text_converter.sv @@
// Converts the ASCII text of a number, one character per input item, most
// significant first, in the radix set by cfg_data (0 binary, 1 hex in either
// case, 2 decimal), and on the item flagged by s_tlast emits either a single
// invalid result or the value as binary digit characters followed by
// uppercase hex digit characters, no leading zeros, '0' for zero. A bad
// digit, too many binary or hex digits, or a decimal value above
// 2^VALUE_BITS-1 makes the string invalid. Non-final characters are taken
// back to back. After the final character of a valid string the input is
// held while the leading-zero scan walks the bit pointer down one position
// per cycle and while B + ceil(B/4) results follow at one per cycle while
// m_tready is high, where B is the binary digit count. An invalid string
// gives its one result through the ST_BAD state and the output register once
// that register is free. The output register lets the next string's characters
// be taken while the last result still waits. Write the radix only while idle.
module radix_text_converter
    import rtc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int M_DATA_W   = ((VALUE_BITS + 8 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,   // input_radix
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // char_code
    input  logic                s_tlast,    // final_char
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // number_value, digit_char, zero fill
    output logic [1:0]          m_tuser,    // bad_input, digit_kind
    output logic                m_tlast     // run_end
);

    logic [1:0] radix_reg;
    rtc_cmd_t   cmd;
    rtc_stat_t  stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_BIN;
        end else if (cfg_valid) begin
            radix_reg <= cfg_data;
        end
    end

    rtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtc_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .M_DATA_W   (M_DATA_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .radix    (radix_reg),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hdl/rtc_ctrl.sv @@
module rtc_ctrl
    import rtc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  rtc_stat_t stat,
    output rtc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BIN,
        ST_HEX,
        ST_BAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.step = 1'b1;
                    if (s_tlast) begin
                        state_next = stat.step_bad ? ST_BAD : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.bit_hit) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_BIN;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            ST_BIN: begin
                if (stat.out_free) begin
                    cmd.emit_bin = 1'b1;
                    if (stat.ptr_zero) begin
                        state_next = ST_HEX;
                    end
                end
            end
            ST_HEX: begin
                if (stat.out_free) begin
                    cmd.emit_hex = 1'b1;
                    if (stat.nib_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD: begin
                if (stat.out_free) begin
                    cmd.emit_bad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.step, cmd.scan, cmd.latch, cmd.emit_bin, cmd.emit_hex, cmd.emit_bad}))
        else $error("more than one datapath command at once");

    a_emit_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_bin || cmd.emit_hex || cmd.emit_bad) |-> stat.out_free)
        else $error("result loaded while output register is occupied");

    a_last_hex_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_hex && stat.nib_zero) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after last hex digit");
`endif

endmodule

@@ hdl/rtc_datapath.sv @@
module rtc_datapath
    import rtc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int M_DATA_W   = ((VALUE_BITS + 8 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          radix,
    input  logic [7:0]          s_tdata,    // char_code
    input  rtc_cmd_t            cmd,
    output rtc_stat_t           stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // number_value, digit_char, zero fill
    output logic [1:0]          m_tuser,    // bad_input, digit_kind
    output logic                m_tlast
);

    localparam int CNT_W     = $clog2(VALUE_BITS + 2);
    localparam int PTR_W     = $clog2(VALUE_BITS);
    localparam int HEXD_MAX  = (VALUE_BITS + 3) / 4;
    localparam int NIB_W     = (HEXD_MAX > 1) ? $clog2(HEXD_MAX) : 1;
    localparam int HEX_W     = HEXD_MAX * 4;
    localparam int DEC_W     = VALUE_BITS + 4;

    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(VALUE_BITS + 1);
    localparam logic [CNT_W-1:0] BIN_LIMIT = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] HEX_LIMIT = CNT_W'(VALUE_BITS / 4);
    localparam logic [PTR_W-1:0] PTR_TOP   = PTR_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] acc_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  inv_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [NIB_W-1:0]      nib_reg;
    logic                  m_valid_reg;

    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_bad_reg;
    logic [7:0]            out_char_reg;
    logic                  out_kind_reg;
    logic                  out_last_reg;

    logic                  dig_ok;
    logic [3:0]            dig;
    logic [CNT_W-1:0]      cnt_inc;
    logic [DEC_W-1:0]      dec_prod;
    logic [VALUE_BITS-1:0] acc_step;
    logic                  over;
    logic                  inv_next;
    logic [HEX_W-1:0]      acc_pad;
    logic [3:0]            nibble;
    logic [7:0]            hex_char;
    logic                  clear_str;

    // digit decode
    always_comb begin
        dig_ok = 1'b0;
        dig    = 4'd0;
        unique case (radix)
            RADIX_BIN: begin
                if (s_tdata == CHAR_ZERO || s_tdata == CHAR_ONE) begin
                    dig_ok = 1'b1;
                    dig    = 4'(s_tdata - CHAR_ZERO);
                end
            end
            RADIX_HEX: begin
                if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE) begin
                    dig_ok = 1'b1;
                    dig    = 4'(s_tdata - CHAR_ZERO);
                end else if (s_tdata >= CHAR_UPPER_A && s_tdata <= CHAR_UPPER_F) begin
                    dig_ok = 1'b1;
                    dig    = 4'(s_tdata - HEX_UPPER_OFS);
                end else if (s_tdata >= CHAR_LOWER_A && s_tdata <= CHAR_LOWER_F) begin
                    dig_ok = 1'b1;
                    dig    = 4'(s_tdata - HEX_LOWER_OFS);
                end
            end
            RADIX_DEC: begin
                if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE) begin
                    dig_ok = 1'b1;
                    dig    = 4'(s_tdata - CHAR_ZERO);
                end
            end
            default: begin
                dig_ok = 1'b0;
            end
        endcase
    end

    assign cnt_inc  = (count_reg < COUNT_CAP) ? count_reg + CNT_W'(1) : count_reg;
    assign dec_prod = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + DEC_W'(dig);

    // accumulate one digit
    always_comb begin
        acc_step = acc_reg;
        over     = 1'b0;
        if (dig_ok) begin
            unique case (radix)
                RADIX_BIN: begin
                    acc_step = {acc_reg[VALUE_BITS-2:0], dig[0]};
                    over     = (cnt_inc > BIN_LIMIT);
                end
                RADIX_HEX: begin
                    acc_step = {acc_reg[VALUE_BITS-5:0], dig};
                    over     = (cnt_inc > HEX_LIMIT);
                end
                default: begin
                    if (|dec_prod[DEC_W-1:VALUE_BITS]) begin
                        over     = 1'b1;
                        acc_step = '1;
                    end else begin
                        acc_step = dec_prod[VALUE_BITS-1:0];
                    end
                end
            endcase
        end
    end

    assign inv_next = inv_reg | ~dig_ok | over;

    assign acc_pad  = HEX_W'(acc_reg);
    assign nibble   = acc_pad[{nib_reg, 2'b00} +: 4];
    assign hex_char = (nibble < 4'd10) ? (CHAR_ZERO + 8'(nibble)) : (HEX_UPPER_OFS + 8'(nibble));

    assign clear_str = cmd.emit_bad | (cmd.emit_hex & (nib_reg == '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            count_reg   <= '0;
            inv_reg     <= 1'b0;
            ptr_reg     <= PTR_TOP;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit_bin || cmd.emit_hex || cmd.emit_bad) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.step) begin
                acc_reg   <= acc_step;
                count_reg <= cnt_inc;
                inv_reg   <= inv_next;
            end
            if (cmd.scan || (cmd.emit_bin && ptr_reg != '0)) begin
                ptr_reg <= ptr_reg - PTR_W'(1);
            end
            if (clear_str) begin
                acc_reg   <= '0;
                count_reg <= '0;
                inv_reg   <= 1'b0;
                ptr_reg   <= PTR_TOP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            nib_reg <= NIB_W'(ptr_reg >> 2);
        end else if (cmd.emit_hex && nib_reg != '0) begin
            nib_reg <= nib_reg - NIB_W'(1);
        end
        if (cmd.emit_bin) begin
            out_value_reg <= acc_reg;
            out_bad_reg   <= 1'b0;
            out_char_reg  <= CHAR_ZERO + 8'(acc_reg[ptr_reg]);
            out_kind_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end else if (cmd.emit_hex) begin
            out_value_reg <= acc_reg;
            out_bad_reg   <= 1'b0;
            out_char_reg  <= hex_char;
            out_kind_reg  <= 1'b1;
            out_last_reg  <= (nib_reg == '0);
        end else if (cmd.emit_bad) begin
            out_value_reg <= '0;
            out_bad_reg   <= 1'b1;
            out_char_reg  <= 8'd0;
            out_kind_reg  <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign stat.out_free = ~m_valid_reg | m_tready;
    assign stat.step_bad = inv_next;
    assign stat.bit_hit  = acc_reg[ptr_reg] | (ptr_reg == '0);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.nib_zero = (nib_reg == '0);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({out_char_reg, out_value_reg});
    assign m_tuser  = {out_kind_reg, out_bad_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_bad_reg) |->
            (out_last_reg && out_char_reg == 8'd0 && out_value_reg == '0 && !out_kind_reg))
        else $error("invalid result carries data");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_CAP)
        else $error("digit count above saturation value");

    a_hex_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_kind_reg && !out_bad_reg) |->
            ((out_char_reg >= CHAR_ZERO && out_char_reg <= CHAR_NINE) ||
             (out_char_reg >= CHAR_UPPER_A && out_char_reg <= CHAR_UPPER_F)))
        else $error("hex result is not an uppercase hex digit");
`endif

endmodule

@@ tb/radix_text_converter_tb.sv @@
module radix_text_converter_tb;
    import rtc_pkg::*;

    localparam int VB = VALUE_BITS_DEF;
    localparam int DW = ((VB + 8 + 7) / 8) * 8;
    localparam logic [1:0] RADIX_UNUSED = 2'd3;
    localparam longint VALUE_MAX = (longint'(1) << VB) - 1;
    localparam int HEX_LIMIT = VB / 4;
    localparam int DEC_DIGITS = 9;
    localparam int COUNT_CAP = VB + 1;
    localparam int DRAIN_CYCLES = VB + 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 480;

    typedef struct packed {
        logic [VB-1:0] value;
        logic          bad;
        logic [7:0]    ch;
        logic          kind;
        logic          last;
    } digit_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [1:0]    cfg_data = 2'd0;
    logic          s_tvalid = 1'b0;
    logic [7:0]    s_tdata = 8'd0;
    logic          s_tlast = 1'b0;
    logic          m_tready = 1'b0;
    logic          cfg_ready;
    logic          s_tready;
    logic          m_tvalid;
    logic [DW-1:0] m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;

    // converter state as the stream sees it
    logic [1:0]    radix_q = RADIX_BIN;
    logic [VB-1:0] acc_q = '0;
    int            count_q = 0;
    logic          bad_q = 1'b0;

    digit_result_t digits_due[$];
    logic [7:0]    text_q[$];
    int            mismatches = 0;
    int            items_sent = 0;
    int            burst_left = 0;
    int            stall_tick = 0;
    int            stall_mode = 0;
    int            watchdog_cycles = 0;

    always #5 aclk = ~aclk;

    radix_text_converter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    function automatic int digit_value(logic [7:0] c, logic [1:0] radix);
        case (radix)
            RADIX_BIN: begin
                if (c == CHAR_ZERO || c == CHAR_ONE) return c - CHAR_ZERO;
            end
            RADIX_HEX: begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return c - HEX_UPPER_OFS;
                if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return c - HEX_LOWER_OFS;
            end
            RADIX_DEC: begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
            end
            default: ;
        endcase
        return -1;
    endfunction

    function automatic logic [7:0] random_digit(logic [1:0] radix);
        int d;
        case (radix)
            RADIX_BIN: return CHAR_ZERO + 8'($urandom_range(0, 1));
            RADIX_HEX: begin
                d = $urandom_range(0, 15);
                if (d < 10) return CHAR_ZERO + 8'(d);
                if ($urandom_range(0, 1) == 1) return HEX_UPPER_OFS + 8'(d);
                return HEX_LOWER_OFS + 8'(d);
            end
            RADIX_DEC: return CHAR_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // accumulate one character, queue the digit run on the final one
    task automatic convert_char(logic [7:0] c, logic fin);
        int            d;
        longint        v;
        int            nbits;
        int            nhex;
        logic [3:0]    nib;
        digit_result_t r;
        d = digit_value(c, radix_q);
        if (count_q < COUNT_CAP) count_q++;
        if (d < 0) begin
            bad_q = 1'b1;
        end else if (radix_q == RADIX_BIN) begin
            acc_q = {acc_q[VB-2:0], d[0]};
            if (count_q > VB) bad_q = 1'b1;
        end else if (radix_q == RADIX_HEX) begin
            acc_q = {acc_q[VB-5:0], d[3:0]};
            if (count_q > HEX_LIMIT) bad_q = 1'b1;
        end else begin
            v = longint'(acc_q) * 10 + d;
            if (v > VALUE_MAX) begin
                bad_q = 1'b1;
                v = VALUE_MAX;
            end
            acc_q = v[VB-1:0];
        end
        if (!fin) return;
        if (bad_q) begin
            r = '{value: '0, bad: 1'b1, ch: 8'd0, kind: 1'b0, last: 1'b1};
            digits_due.push_back(r);
        end else begin
            nbits = 1;
            while (nbits < VB && (acc_q >> nbits) != 0) nbits++;
            nhex = (nbits + 3) / 4;
            for (int i = nbits - 1; i >= 0; i--) begin
                r = '{value: acc_q, bad: 1'b0, ch: CHAR_ZERO + 8'(acc_q[i]),
                      kind: 1'b0, last: 1'b0};
                digits_due.push_back(r);
            end
            for (int i = nhex - 1; i >= 0; i--) begin
                nib = 4'(acc_q >> (4 * i));
                r = '{value: acc_q, bad: 1'b0,
                      ch: (nib < 10) ? CHAR_ZERO + 8'(nib) : HEX_UPPER_OFS + 8'(nib),
                      kind: 1'b1, last: (i == 0)};
                digits_due.push_back(r);
            end
        end
        acc_q = '0;
        count_q = 0;
        bad_q = 1'b0;
    endtask

    task automatic send_char(logic [7:0] c, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= fin;
        do @(posedge aclk); while (!s_tready);
        convert_char(c, fin);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(8'(s[i]), i == s.len() - 1);
    endtask

    task automatic send_queued_text();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    endtask

    // sender quiet until every digit has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (digits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radix(logic [1:0] radix);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= radix;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radix_q = radix;
    endtask

    task automatic build_text(logic [1:0] radix);
        int     roll;
        int     len;
        int     limit;
        longint v;
        text_q.delete();
        roll = $urandom_range(0, 99);
        limit = (radix == RADIX_BIN) ? VB : (radix == RADIX_HEX) ? HEX_LIMIT : DEC_DIGITS;
        if (roll < 15) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
                if ($urandom_range(0, 1) == 1) text_q.push_back(8'($urandom_range(0, 255)));
                else text_q.push_back(random_digit(radix));
            end
            return;
        end
        if (radix == RADIX_DEC && roll < 45) begin
            if (roll < 25) v = VALUE_MAX - 2 + $urandom_range(0, 4);
            else if (roll < 35) v = longint'($urandom());
            else v = $urandom_range(0, 999);
            if (v == 0) text_q.push_back(CHAR_ZERO);
            while (v > 0) begin
                text_q.push_front(CHAR_ZERO + 8'(v % 10));
                v = v / 10;
            end
            if ($urandom_range(0, 3) == 0) text_q.push_front(CHAR_ZERO);
            return;
        end
        if (roll < 60) len = $urandom_range(1, 4);
        else if (roll < 80) len = $urandom_range(1, limit);
        else if (roll < 90) len = limit;
        else len = limit + $urandom_range(1, 3);
        repeat (len) text_q.push_back(random_digit(radix));
        // broken string: one stray byte somewhere
        if ($urandom_range(0, 19) == 0) text_q[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h, %0d items sent",
                 what, got, want, items_sent);
        mismatches++;
    endtask

    // result side: check each item, stall on a pattern chosen at random
    always @(posedge aclk) begin : digit_check
        digit_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digits_due.size() == 0) begin
                report_mismatch("unexpected item", longint'(m_tdata), 0);
            end else begin
                want = digits_due.pop_front();
                if (m_tdata[VB-1:0] !== want.value)
                    report_mismatch("number_value", m_tdata[VB-1:0], want.value);
                if (m_tuser[0] !== want.bad) report_mismatch("bad_input", m_tuser[0], want.bad);
                if (m_tdata[VB+7:VB] !== want.ch)
                    report_mismatch("digit_char", m_tdata[VB+7:VB], want.ch);
                if (m_tuser[1] !== want.kind) report_mismatch("digit_kind", m_tuser[1], want.kind);
                if (m_tlast !== want.last) report_mismatch("run_end", m_tlast, want.last);
            end
        end
        stall_tick++;
        if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_tick % 4 != 0);
            default: m_tready <= (stall_tick % 16 < 3);
        endcase
    end

    always @(posedge aclk) begin
        watchdog_cycles++;
        if (watchdog_cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_reset_radix_binary();
        send_text("0");
        send_text("1");
        send_text("0101");
        send_char(CHAR_ONE, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_hex_text();
        write_radix(RADIX_HEX);
        send_text("FFFFFFF");
        send_text("fA");
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_decimal_text();
        write_radix(RADIX_DEC);
        send_text("9");
        send_text("a");
    endtask

    task automatic test_unused_radix();
        write_radix(RADIX_UNUSED);
        send_text("1");
    endtask

    task automatic test_random_strings();
        int target;
        int strings;
        target = items_sent + RANDOM_ITEMS;
        strings = 0;
        while (items_sent < target) begin
            if (strings % 6 == 0) write_radix(2'($urandom_range(0, 2)));
            else if (strings % 23 == 11) settle();
            build_text(radix_q);
            send_queued_text();
            strings++;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_radix_binary();
        test_hex_text();
        test_decimal_text();
        test_unused_radix();
        test_random_strings();
        settle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/rtc_pkg.sv
hdl/rtc_ctrl.sv
hdl/rtc_datapath.sv
hdl/radix_text_converter.sv
tb/radix_text_converter_tb.sv
